>>> sv/hlvp_pkg.sv
package hlvp_pkg;

    // command codes of the input request
    localparam logic [1:0] CMD_VOTE   = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BLOCK_THETA  = 3'd2;
    localparam logic [2:0] REG_BLOCK_RHO    = 3'd3;
    localparam logic [2:0] REG_THRESHOLD    = 3'd4;

    localparam int THETA_BITS = 8;
    localparam int CNT_BITS   = 16;

    // lengths and rho counts, wide enough for any image size in range
    typedef logic [CNT_BITS-1:0] cnt_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  theta;
        logic [10:0] rho;
        logic [15:0] votes;
    } search_res_t;

    // sin(deg) in unsigned q1.14, deg 0..90
    localparam logic [14:0] SIN_Q14 [91] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    function automatic logic [14:0] sin_q14(input logic [6:0] deg);
        logic [14:0] v;
        v = 15'd0;
        if (deg <= 7'd90)
        begin
            v = SIN_Q14[deg];
        end
        return v;
    endfunction

endpackage

>>> sv/hlvp_accum_mem.sv
module hlvp_accum_mem #(
    parameter int AW    = 19,
    parameter int DW    = 16,
    parameter int DEPTH = 368640
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/hlvp_vote.sv
module hlvp_vote #(
    parameter int RA         = 11,
    parameter int VOTE_BITS  = 16,
    parameter int RHO_CAP    = 2048,
    parameter int ANGLE_BINS = 180
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [8:0]           px,
    input  logic [8:0]           py,
    input  hlvp_pkg::cnt_t       len,
    output logic                 busy,
    output logic [RA+7:0]        rd_addr,
    input  logic [VOTE_BITS-1:0] rd_data,
    output logic                 wr_en,
    output logic [RA+7:0]        wr_addr,
    output logic [VOTE_BITS-1:0] wr_data
);

    logic                 run_reg, run_next;
    logic [7:0]           ang_reg, ang_next;
    logic [8:0]           px_reg, py_reg;
    hlvp_pkg::cnt_t       len_reg;
    logic                 s1_vld_reg;
    logic [7:0]           s1_ang_reg;
    logic signed [25:0]   s1_pxc_reg, s1_pys_reg;
    logic                 s2_vld_reg;
    logic [RA+7:0]        s2_addr_reg;

    logic [6:0]           ad;
    logic [14:0]          cos_u, sin_u;
    logic signed [15:0]   cos_s, sin_s;
    logic signed [25:0]   pxc, pys;
    logic signed [31:0]   r_sum, lim, pos;
    logic [17:0]          bin;
    logic                 hit;

    // stage 0: angle counter, table lookup and the two products
    assign ad    = (ang_reg < 8'd90) ? 7'(8'd90 - ang_reg) : 7'(ang_reg - 8'd90);
    assign cos_u = hlvp_pkg::sin_q14(7'(7'd90 - ad));
    assign sin_u = hlvp_pkg::sin_q14(ad);
    assign cos_s = signed'({1'b0, cos_u});
    assign sin_s = (ang_reg < 8'd90) ? -signed'({1'b0, sin_u}) : signed'({1'b0, sin_u});
    assign pxc   = signed'({1'b0, px_reg}) * cos_s;
    assign pys   = signed'({1'b0, py_reg}) * sin_s;

    // stage 1: sum, range check, read address
    assign r_sum   = 32'(s1_pxc_reg) + 32'(s1_pys_reg);
    assign lim     = signed'({2'b00, len_reg, 14'd0});
    assign pos     = lim + r_sum;
    assign bin     = pos[31:14];
    assign hit     = s1_vld_reg && (r_sum > -lim) && (r_sum < lim) && (bin < 18'(RHO_CAP));
    assign rd_addr = {s1_ang_reg, bin[RA-1:0]};

    // stage 2: saturating increment and write back
    assign wr_en   = s2_vld_reg;
    assign wr_addr = s2_addr_reg;
    assign wr_data = (&rd_data) ? rd_data : rd_data + VOTE_BITS'(1);

    assign busy = run_reg | s1_vld_reg | s2_vld_reg;

    always_comb
    begin
        run_next = run_reg;
        ang_next = ang_reg;
        if (start)
        begin
            run_next = 1'b1;
            ang_next = 8'd0;
        end
        else if (run_reg)
        begin
            ang_next = ang_reg + 8'd1;
            if (ang_reg == 8'(ANGLE_BINS - 1))
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            ang_reg    <= 8'd0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            run_reg    <= run_next;
            ang_reg    <= ang_next;
            s1_vld_reg <= run_reg;
            s2_vld_reg <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            px_reg  <= px;
            py_reg  <= py;
            len_reg <= len;
        end
        s1_ang_reg  <= ang_reg;
        s1_pxc_reg  <= pxc;
        s1_pys_reg  <= pys;
        s2_addr_reg <= rd_addr;
    end

endmodule

>>> sv/hlvp_search.sv
module hlvp_search #(
    parameter int RA         = 11,
    parameter int VOTE_BITS  = 16,
    parameter int ANGLE_BINS = 180
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [7:0]            t0,
    input  logic [10:0]           r0,
    input  logic [7:0]            bts,
    input  logic [11:0]           brs,
    input  hlvp_pkg::cnt_t        rho_bins,
    input  logic [15:0]           thr,
    output logic [RA+7:0]         rd_addr,
    input  logic [VOTE_BITS-1:0]  rd_data,
    output logic                  done,
    output hlvp_pkg::search_res_t res
);

    logic                 run_reg, done_reg, null_reg;
    logic [7:0]           t_reg, rt_reg, bt_reg;
    hlvp_pkg::cnt_t       r_reg, r0_reg, rend_reg;
    logic [8:0]           tend_reg;
    logic [10:0]          rr_reg, br_reg;
    logic                 rv_reg, rlast_reg, rfirst_reg, first_reg;
    logic [VOTE_BITS-1:0] best_reg;

    logic                 oor, zero;
    logic [8:0]           t_sum, t_end;
    hlvp_pkg::cnt_t       r_sum, r_end;
    logic                 r_wrap, last;

    assign oor   = (t0 >= 8'(ANGLE_BINS)) || (hlvp_pkg::cnt_t'(r0) >= rho_bins);
    assign zero  = (bts == 8'd0) || (brs == 12'd0);
    assign t_sum = 9'(t0) + 9'(bts);
    assign r_sum = hlvp_pkg::cnt_t'(r0) + hlvp_pkg::cnt_t'(brs);
    assign t_end = zero ? 9'(t0) + 9'd1 : ((t_sum > 9'(ANGLE_BINS)) ? 9'(ANGLE_BINS) : t_sum);
    assign r_end = zero ? hlvp_pkg::cnt_t'(r0) + 16'd1 : ((r_sum > rho_bins) ? rho_bins : r_sum);

    assign r_wrap  = (r_reg + 16'd1 == rend_reg);
    assign last    = r_wrap && (9'(t_reg) + 9'd1 == tend_reg);
    assign rd_addr = {t_reg, r_reg[RA-1:0]};

    assign done      = done_reg;
    assign res.found = !null_reg && (32'(best_reg) > 32'(thr));
    assign res.theta = null_reg ? 8'd0 : bt_reg;
    assign res.rho   = null_reg ? 11'd0 : br_reg;
    assign res.votes = null_reg ? 16'd0 : 16'(32'(best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            rv_reg <= run_reg;
            if (start)
            begin
                run_reg  <= !oor;
                done_reg <= oor;
            end
            else
            begin
                if (run_reg && last)
                begin
                    run_reg <= 1'b0;
                end
                if (rv_reg && rlast_reg)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            null_reg  <= oor;
            t_reg     <= t0;
            r_reg     <= hlvp_pkg::cnt_t'(r0);
            r0_reg    <= hlvp_pkg::cnt_t'(r0);
            tend_reg  <= t_end;
            rend_reg  <= r_end;
            first_reg <= 1'b1;
        end
        else if (run_reg)
        begin
            first_reg <= 1'b0;
            if (r_wrap)
            begin
                r_reg <= r0_reg;
                t_reg <= t_reg + 8'd1;
            end
            else
            begin
                r_reg <= r_reg + 16'd1;
            end
        end
        // cell coordinates travel alongside the read
        rt_reg     <= t_reg;
        rr_reg     <= 11'(r_reg);
        rlast_reg  <= last;
        rfirst_reg <= first_reg;
        // first strict maximum in scan order
        if (rv_reg && (rfirst_reg || rd_data > best_reg))
        begin
            best_reg <= rd_data;
            bt_reg   <= rt_reg;
            br_reg   <= rr_reg;
        end
    end

endmodule

>>> sv/hough_line_vote_and_peaks.sv
// hough line accumulator with windowed peak search. each request carries a cmd:
// vote (0) casts one vote per angle bin, 180 bins from -90 to 89 degrees, into
// bin floor(w+h+r) of a 16-bit saturating counter array held in one simple
// dual-port ram; a pixel outside the image or with zero edge value does not vote.
// search (1) scans a theta-by-rho window, clipped at theta 180 and rho 2*(w+h),
// and returns one result with the first strict maximum; clear (2) zeroes the ram.
// operation: a voting pixel does one ram read-modify-write per angle bin in a
// three-stage pipeline; a search does one ram read per window cell; a clear,
// and the pass after reset, sweeps the ram one word per cycle over all
// ANGLE_BINS * 2^ceil(log2(2*(MAX_WIDTH+MAX_HEIGHT))) words (368640 at default
// sizes), during which no request is taken. one request is worked at a
// time; a finished result sits in the output register while the next request is
// accepted. configuration is written through cfg_we/cfg_index/cfg_data.
module hough_line_vote_and_peaks #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int ANGLE_BINS = 180,
    parameter int VOTE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [8:0]  pixel_x,
    input  logic [8:0]  pixel_y,
    input  logic [7:0]  edge_value,
    input  logic [7:0]  window_theta_start,
    input  logic [10:0] window_rho_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        peak_found,
    output logic [7:0]  peak_theta,
    output logic [10:0] peak_rho,
    output logic [15:0] peak_votes
);

    localparam int RHO_CAP = 2 * (MAX_WIDTH + MAX_HEIGHT);
    localparam int RA      = $clog2(RHO_CAP);
    localparam int AW      = RA + hlvp_pkg::THETA_BITS;
    // rows are padded to a power of two so the address is {theta, rho}
    localparam int DEPTH   = ANGLE_BINS * (2 ** RA);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_VOTE   = 4'b0100,
        S_SEARCH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [9:0]  image_width_reg, image_height_reg;
    logic [7:0]  block_theta_reg;
    logic [11:0] block_rho_reg;
    logic [15:0] threshold_reg;

    // clear sweep
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    hlvp_pkg::search_res_t out_res_reg;

    // effective image size and derived lengths
    hlvp_pkg::cnt_t w_eff, h_eff, len, rho_bins;

    logic accept, votes_pixel, vote_start, srch_start, load_out;

    // ram ports
    logic [AW-1:0]        mem_rd_addr, mem_wr_addr;
    logic                 mem_we;
    logic [VOTE_BITS-1:0] mem_wr_data, mem_rd_data;

    logic [AW-1:0]        vote_rd_addr, vote_wr_addr, srch_rd_addr;
    logic                 vote_we, vote_busy, srch_done;
    logic [VOTE_BITS-1:0] vote_wr_data;
    hlvp_pkg::search_res_t srch_res;

    // sizes above the build limits act as the limits
    assign w_eff = (hlvp_pkg::cnt_t'(image_width_reg) > hlvp_pkg::cnt_t'(MAX_WIDTH))
                   ? hlvp_pkg::cnt_t'(MAX_WIDTH) : hlvp_pkg::cnt_t'(image_width_reg);
    assign h_eff = (hlvp_pkg::cnt_t'(image_height_reg) > hlvp_pkg::cnt_t'(MAX_HEIGHT))
                   ? hlvp_pkg::cnt_t'(MAX_HEIGHT) : hlvp_pkg::cnt_t'(image_height_reg);
    assign len      = w_eff + h_eff;
    assign rho_bins = {len[14:0], 1'b0};

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // only nonzero pixels inside the image start the angle sweep
    assign votes_pixel = (edge_value != 8'd0)
                         && (hlvp_pkg::cnt_t'(pixel_x) < w_eff)
                         && (hlvp_pkg::cnt_t'(pixel_y) < h_eff);
    assign vote_start  = accept && (cmd == hlvp_pkg::CMD_VOTE) && votes_pixel;
    assign srch_start  = accept && (cmd == hlvp_pkg::CMD_SEARCH);

    // search result waits until the output register is free
    assign load_out = (state_reg == S_SEARCH) && srch_done && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        hlvp_pkg::CMD_VOTE:
                        begin
                            if (votes_pixel)
                            begin
                                state_next = S_VOTE;
                            end
                        end
                        hlvp_pkg::CMD_SEARCH:
                        begin
                            state_next = S_SEARCH;
                        end
                        hlvp_pkg::CMD_CLEAR:
                        begin
                            state_next   = S_CLEAR;
                            clr_cnt_next = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_VOTE:
            begin
                // last write back done before the next request can touch the ram
                if (!vote_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
            image_width_reg  <= 10'd512;
            image_height_reg <= 10'd512;
            block_theta_reg  <= 8'd10;
            block_rho_reg    <= 12'd10;
            threshold_reg    <= 16'd100;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    hlvp_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[9:0];
                    hlvp_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[9:0];
                    hlvp_pkg::REG_BLOCK_THETA:  block_theta_reg  <= cfg_data[7:0];
                    hlvp_pkg::REG_BLOCK_RHO:    block_rho_reg    <= cfg_data[11:0];
                    hlvp_pkg::REG_THRESHOLD:    threshold_reg    <= cfg_data;
                    default:                    image_width_reg  <= image_width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_res_reg <= srch_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign peak_found = out_res_reg.found;
    assign peak_theta = out_res_reg.theta;
    assign peak_rho   = out_res_reg.rho;
    assign peak_votes = out_res_reg.votes;

    // ram port steering: the clear sweep owns the write port in its state
    assign mem_rd_addr = (state_reg == S_SEARCH) ? srch_rd_addr : vote_rd_addr;
    assign mem_we      = (state_reg == S_CLEAR) ? 1'b1 : vote_we;
    assign mem_wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : vote_wr_addr;
    assign mem_wr_data = (state_reg == S_CLEAR) ? '0 : vote_wr_data;

    hlvp_accum_mem #(
        .AW    (AW),
        .DW    (VOTE_BITS),
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    hlvp_vote #(
        .RA         (RA),
        .VOTE_BITS  (VOTE_BITS),
        .RHO_CAP    (RHO_CAP),
        .ANGLE_BINS (ANGLE_BINS)
    ) u_vote (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (vote_start),
        .px      (pixel_x),
        .py      (pixel_y),
        .len     (len),
        .busy    (vote_busy),
        .rd_addr (vote_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (vote_we),
        .wr_addr (vote_wr_addr),
        .wr_data (vote_wr_data)
    );

    hlvp_search #(
        .RA         (RA),
        .VOTE_BITS  (VOTE_BITS),
        .ANGLE_BINS (ANGLE_BINS)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (srch_start),
        .t0       (window_theta_start),
        .r0       (window_rho_start),
        .bts      (block_theta_reg),
        .brs      (block_rho_reg),
        .rho_bins (rho_bins),
        .thr      (threshold_reg),
        .rd_addr  (srch_rd_addr),
        .rd_data  (mem_rd_data),
        .done     (srch_done),
        .res      (srch_res)
    );

`ifndef SYNTH
    // a result only appears at the end of a search
    a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_SEARCH))
        else $error("result without search");

    // the vote pipeline is drained whenever the ram is handed to anyone else
    a_vote_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_VOTE) |-> !vote_busy)
        else $error("vote pipeline active outside vote state");

    // no ram write while requests are being taken
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("ram write while idle");
`endif

endmodule

>>> verif/hough_line_vote_and_peaks_tb.sv
module hough_line_vote_and_peaks_tb;

    localparam int RHO_CAP    = 2048;
    localparam int THETA_BINS = 180;
    // the limit leaves room for the reset and clear sweeps, two of them run here
    localparam int CYCLE_LIMIT = 10000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD = 3000;
    // command code with no function, and a register index beyond the list
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // expected peaks and a private copy of the vote counters
    class peak_scoreboard;
        bit [15:0]             vote_count [];
        hlvp_pkg::search_res_t peak_q [$];
        int unsigned width_reg, height_reg, theta_size, rho_size, threshold;
        int          errors;

        function new();
            vote_count = new[THETA_BINS * RHO_CAP];
            width_reg  = 512;
            height_reg = 512;
            theta_size = 10;
            rho_size   = 10;
            threshold  = 100;
            errors     = 0;
        endfunction

        function int unsigned eff_w();
            return (width_reg > 512) ? 512 : width_reg;
        endfunction

        function int unsigned eff_h();
            return (height_reg > 512) ? 512 : height_reg;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                hlvp_pkg::REG_IMAGE_WIDTH:  width_reg  = data[9:0];
                hlvp_pkg::REG_IMAGE_HEIGHT: height_reg = data[9:0];
                hlvp_pkg::REG_BLOCK_THETA:  theta_size = data[7:0];
                hlvp_pkg::REG_BLOCK_RHO:    rho_size   = data[11:0];
                hlvp_pkg::REG_THRESHOLD:    threshold  = data[15:0];
                default: ;
            endcase
        endfunction

        function void cast_votes(int x, int y);
            int w, h, lim, d, ad, c, s, r, bin, idx;
            w = eff_w();
            h = eff_h();
            lim = (w + h) * 16384;
            if (x >= w || y >= h)
                return;
            for (int a = 0; a < THETA_BINS; a++)
            begin
                d  = a - 90;
                ad = (d < 0) ? -d : d;
                c  = int'(hlvp_pkg::SIN_Q14[90 - ad]);
                s  = (d < 0) ? -int'(hlvp_pkg::SIN_Q14[ad]) : int'(hlvp_pkg::SIN_Q14[ad]);
                r  = x * c + y * s;
                if (r > -lim && r < lim)
                begin
                    bin = (lim + r) >>> 14;
                    if (bin < RHO_CAP)
                    begin
                        idx = a * RHO_CAP + bin;
                        if (vote_count[idx] != 16'hffff)
                            vote_count[idx] = vote_count[idx] + 16'd1;
                    end
                end
            end
        endfunction

        function hlvp_pkg::search_res_t find_peak(int t0, int r0);
            hlvp_pkg::search_res_t res;
            int rho_bins, t_end, r_end, bt, br;
            bit [15:0] best;
            res = '0;
            rho_bins = 2 * (eff_w() + eff_h());
            if (t0 >= THETA_BINS || r0 >= rho_bins)
                return res;
            t_end = t0 + theta_size;
            if (t_end > THETA_BINS)
                t_end = THETA_BINS;
            r_end = r0 + rho_size;
            if (r_end > rho_bins)
                r_end = rho_bins;
            bt = t0;
            br = r0;
            best = vote_count[t0 * RHO_CAP + r0];
            for (int t = t0; t < t_end; t++)
                for (int r = r0; r < r_end; r++)
                    if (vote_count[t * RHO_CAP + r] > best)
                    begin
                        best = vote_count[t * RHO_CAP + r];
                        bt = t;
                        br = r;
                    end
            res.found = (best > threshold);
            res.theta = bt[7:0];
            res.rho   = br[10:0];
            res.votes = best;
            return res;
        endfunction

        function void note_request(logic [1:0] c, logic [8:0] x, logic [8:0] y,
                                   logic [7:0] e, logic [7:0] t0, logic [10:0] r0);
            case (c)
                hlvp_pkg::CMD_VOTE:   if (e != 0) cast_votes(int'(x), int'(y));
                hlvp_pkg::CMD_SEARCH: peak_q = {peak_q, find_peak(int'(t0), int'(r0))};
                hlvp_pkg::CMD_CLEAR:  foreach (vote_count[i]) vote_count[i] = 16'd0;
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(hlvp_pkg::search_res_t got);
            hlvp_pkg::search_res_t want;
            if (peak_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected peak %p", got));
                return;
            end
            want = peak_q.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found %0d want %0d", got.found, want.found));
            if (got.theta !== want.theta)
                report_mismatch($sformatf("theta %0d want %0d", got.theta, want.theta));
            if (got.rho !== want.rho)
                report_mismatch($sformatf("rho %0d want %0d", got.rho, want.rho));
            if (got.votes !== want.votes)
                report_mismatch($sformatf("votes %0d want %0d", got.votes, want.votes));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = '0;
    logic [8:0]  pixel_x = '0;
    logic [8:0]  pixel_y = '0;
    logic [7:0]  edge_value = '0;
    logic [7:0]  window_theta_start = '0;
    logic [10:0] window_rho_start = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        peak_found;
    logic [7:0]  peak_theta;
    logic [10:0] peak_rho;
    logic [15:0] peak_votes;

    peak_scoreboard sb;
    idle_mode_t     idle_mode = IDLE_NONE;
    bit             hold_req = 1'b0;
    int             hold_left = 0;
    longint         cycles = 0;

    hough_line_vote_and_peaks dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .pixel_x(pixel_x), .pixel_y(pixel_y), .edge_value(edge_value),
        .window_theta_start(window_theta_start), .window_rho_start(window_rho_start),
        .out_valid(out_valid), .out_ready(out_ready),
        .peak_found(peak_found), .peak_theta(peak_theta),
        .peak_rho(peak_rho), .peak_votes(peak_votes)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // watchdog, covers a hung handshake as well as a stuck clear sweep
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls per phase, plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_mode == IDLE_RECV)
            out_ready <= ($urandom_range(99) >= 82);
        else if (idle_mode == IDLE_BOTH)
            out_ready <= ($urandom_range(99) >= 36);
        else
            out_ready <= 1'b1;
    end

    // monitor: values seen here are the ones taken at this edge
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (in_valid && in_ready)
                sb.note_request(cmd, pixel_x, pixel_y, edge_value,
                                window_theta_start, window_rho_start);
            if (out_valid && out_ready)
                sb.check_result(hlvp_pkg::search_res_t'{found: peak_found,
                                                        theta: peak_theta,
                                                        rho: peak_rho,
                                                        votes: peak_votes});
        end
    end

    // one request; valid stays up across back-to-back requests
    task send_request(logic [1:0] c, logic [8:0] x, logic [8:0] y, logic [7:0] e,
                      logic [7:0] t0, logic [10:0] r0);
        int gap;
        int pct;
        gap = 0;
        pct = (idle_mode == IDLE_SEND) ? 82 : (idle_mode == IDLE_BOTH) ? 36 : 0;
        while (gap < 40 && $urandom_range(99) < pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        pixel_x <= x;
        pixel_y <= y;
        edge_value <= e;
        window_theta_start <= t0;
        window_rho_start <= r0;
        do @(posedge clk); while (!in_ready);
    endtask

    task vote(int x, int y, int e);
        send_request(hlvp_pkg::CMD_VOTE, x[8:0], y[8:0], e[7:0], 8'($urandom),
                     11'($urandom));
    endtask

    task search(int t0, int r0);
        send_request(hlvp_pkg::CMD_SEARCH, 9'($urandom), 9'($urandom), 8'($urandom),
                     t0[7:0], r0[10:0]);
    endtask

    // wait for every peak, then let a trailing vote finish
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.peak_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task set_reg(logic [2:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task set_image(int w, int h, int ts, int rs, int thr);
        set_reg(hlvp_pkg::REG_IMAGE_WIDTH, w[15:0]);
        set_reg(hlvp_pkg::REG_IMAGE_HEIGHT, h[15:0]);
        set_reg(hlvp_pkg::REG_BLOCK_THETA, ts[15:0]);
        set_reg(hlvp_pkg::REG_BLOCK_RHO, rs[15:0]);
        set_reg(hlvp_pkg::REG_THRESHOLD, thr[15:0]);
    endtask

    // mostly in-image votes and in-range searches, some noise
    task run_phase(int n, idle_mode_t mode, bit long_hold, bit mid_pause);
        int w, h, rho_bins, pick, x, y, t0, r0;
        idle_mode = mode;
        w = sb.eff_w();
        h = sb.eff_h();
        rho_bins = 2 * (w + h);
        if (long_hold)
            hold_req = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (mid_pause && i == n / 2)
                drain();
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                x = (w > 0) ? $urandom_range(w - 1) : $urandom_range(511);
                y = (h > 0) ? $urandom_range(h - 1) : $urandom_range(511);
                vote(x, y, $urandom_range(255, 1));
            end
            else if (pick < 62)
                vote($urandom_range(511), $urandom_range(511), $urandom_range(255));
            else if (pick < 93)
            begin
                t0 = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(179);
                r0 = ($urandom_range(7) == 0) ? $urandom_range(2047)
                                              : $urandom_range(rho_bins - 1);
                search(t0, r0);
            end
            else if (pick < 97)
                send_request(CMD_UNUSED, 9'($urandom), 9'($urandom), 8'($urandom),
                             8'($urandom), 11'($urandom));
            else
                vote($urandom_range(511), $urandom_range(511), 0);
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed, default 512x512 image; first request waits out the reset sweep
        vote(0, 0, 255);
        vote(511, 511, 1);
        vote(511, 0, 128);
        vote(0, 511, 7);
        vote(5, 5, 0);
        send_request(CMD_UNUSED, 9'h1ff, 9'h1ff, 8'hff, 8'hff, 11'h7ff);
        search(90, 1020);
        search(0, 0);
        search(179, 2047);
        search(255, 100);
        send_request(hlvp_pkg::CMD_CLEAR, '0, '0, '0, '0, '0);
        search(90, 1020);
        drain();

        // small image, single-cell window, two votes fall outside the image
        set_image(20, 12, 0, 0, 0);
        set_reg(REG_UNUSED, 16'hffff);
        vote(25, 3, 9);
        vote(3, 15, 9);
        vote(19, 11, 200);
        vote(19, 11, 200);
        search(90, 51);
        search(90, 50);
        search(0, 64);
        search(0, 63);
        drain();

        set_image(512, 512, 10, 10, 0);
        run_phase(100, IDLE_NONE, 1'b0, 1'b0);
        set_image(40, 30, 8, 16, 2);
        run_phase(100, IDLE_SEND, 1'b0, 1'b1);
        // tiny image so the full-size window clips to a few hundred cells
        set_image(1, 1, 180, 4095, 0);
        run_phase(70, IDLE_RECV, 1'b0, 1'b0);
        // width above range acts as the maximum, zero height never votes
        set_image(1023, 0, 0, 0, 65535);
        run_phase(50, IDLE_BOTH, 1'b0, 1'b0);
        // long receiver hold-off fills the output register and stalls input
        set_image(64, 64, 20, 30, 3);
        run_phase(100, IDLE_NONE, 1'b1, 1'b0);
        set_image(300, 7, 255, 5, 1);
        run_phase(100, IDLE_BOTH, 1'b0, 1'b0);
        set_image(16, 16, 1, 2048, 4);
        run_phase(60, IDLE_SEND, 1'b0, 1'b0);

        idle_mode = IDLE_NONE;
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> hough_line_vote_and_peaks.f
sv/hlvp_pkg.sv
sv/hlvp_accum_mem.sv
sv/hlvp_vote.sv
sv/hlvp_search.sv
sv/hough_line_vote_and_peaks.sv
verif/hough_line_vote_and_peaks_tb.sv
